### rtl/core/vtp_pkg.sv
// Shared types and constants for the vertex transform and perspective divide block.
// Used by vertex_transform_perspective_divide; depends on nothing else.
package vtp_pkg;

  localparam int NUM_MREGS  = 8;
  localparam int DIV_STAGES = 32;

  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  // One divide lane (x, y or z) as it moves down the divider.
  typedef struct packed {
    logic [31:0] rem;   // partial remainder
    logic [31:0] nlo;   // numerator bits not yet consumed, MSB first
    logic [31:0] quo;   // quotient bits produced so far
    logic        neg;   // quotient is negative
    logic        ovf;   // magnitude does not fit in 32 bits
    logic        tneg;  // numerator is negative
    logic        tnz;   // numerator is nonzero
  } vtp_lane_t;

  // Per-vertex data that rides along with the three lanes.
  typedef struct packed {
    logic [31:0] den;   // magnitude of the transformed w
    logic [31:0] w;     // transformed w, saturated
    logic        zw;    // transformed w is zero
    logic        sat;   // a row sum was clipped
  } vtp_side_t;

endpackage

### rtl/core/vertex_transform_perspective_divide.sv
// Top level of the 4x4 homogeneous vertex transform with perspective divide.
// Depends on vtp_pkg for lane types and constants.
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  vertex   | vertex_valid/ready, vertex_x/y/z/w       | in
//  result   | result_valid/ready, out_x/y/z/w, flags   | out
//  cfg      | cfg_valid/ready, cfg_index, cfg_data     | in
//
// A vertex transaction can be accepted every cycle while the pipeline is not stalled.
// The pipeline has one multiply stage, two adder-tree stages, one divide setup stage, 32
// restoring divide stages (one quotient bit each) and the output register.
// The whole pipeline advances together; it stalls only when the output
// register holds a result that the consumer has not taken.
// Reset (synchronous) clears all valid bits and loads the identity matrix.
// Configuration writes are always accepted; indexes beyond 7 are dropped.
module vertex_transform_perspective_divide
  import vtp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        vertex_valid,
  output logic        vertex_ready,
  input  logic [31:0] vertex_x,
  input  logic [31:0] vertex_y,
  input  logic [31:0] vertex_z,
  input  logic [31:0] vertex_w,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic [31:0] out_z,
  output logic [31:0] out_w,
  output logic        w_was_zero,
  output logic        saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int NUM_W = 32 + FRAC_BITS;
  localparam logic [63:0] ONE = 64'(1) << FRAC_BITS;

  // The pipeline moves as one; it holds only while a result waits.
  logic en;
  assign en           = !result_valid || result_ready;
  assign vertex_ready = en;
  assign cfg_ready    = 1'b1;

  // Matrix registers: row R uses mreg[2R] for columns 0/1, mreg[2R+1] for 2/3.
  logic [63:0] mreg [NUM_MREGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      mreg[0] <= ONE;
      mreg[1] <= '0;
      mreg[2] <= ONE << 32;
      mreg[3] <= '0;
      mreg[4] <= '0;
      mreg[5] <= ONE;
      mreg[6] <= '0;
      mreg[7] <= ONE << 32;
    end else if (cfg_valid && !cfg_index[3]) begin
      mreg[cfg_index[2:0]] <= cfg_data;
    end
  end

  // Stage 1: sixteen 32x32 signed products.
  logic [31:0] vin [4];
  assign vin[0] = vertex_x;
  assign vin[1] = vertex_y;
  assign vin[2] = vertex_z;
  assign vin[3] = vertex_w;

  logic               v1;
  logic signed [63:0] prod [4][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= vertex_valid;
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_mul_row
    for (genvar c = 0; c < 4; c++) begin : g_mul_col
      always_ff @(posedge clk) begin
        if (en) begin
          prod[r][c] <= $signed(mreg[r*2 + c/2][(c%2)*32 +: 32]) * $signed(vin[c]);
        end
      end
    end
  end

  // Stage 2: pairwise sums.
  logic        v2;
  logic [64:0] psum [4][2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_pair
    always_ff @(posedge clk) begin
      if (en) begin
        psum[r][0] <= {prod[r][0][63], prod[r][0]} + {prod[r][1][63], prod[r][1]};
        psum[r][1] <= {prod[r][2][63], prod[r][2]} + {prod[r][3][63], prod[r][3]};
      end
    end
  end

  // Stage 3: full row sum, floor shift by the fraction width, clip to 32 bits.
  logic        v3;
  logic [31:0] trow [4];
  logic [3:0]  tsat;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    logic [65:0] full;
    logic [65:0] sh;
    logic        over;
    logic        under;
    assign full  = {psum[r][0][64], psum[r][0]} + {psum[r][1][64], psum[r][1]};
    assign sh    = $unsigned($signed(full) >>> FRAC_BITS);
    assign over  = !sh[65] && (|sh[65:31]);
    assign under = sh[65] && !(&sh[65:31]);
    always_ff @(posedge clk) begin
      if (en) begin
        trow[r] <= over ? S32_MAX : (under ? S32_MIN : sh[31:0]);
        tsat[r] <= over || under;
      end
    end
  end

  // Divider pipeline: index 0 is the setup stage, 1..DIV_STAGES produce
  // one quotient bit each, MSB first.
  logic      vd   [DIV_STAGES + 1];
  vtp_lane_t lane [DIV_STAGES + 1][3];
  vtp_side_t side [DIV_STAGES + 1];

  logic [31:0] den0;
  assign den0 = trow[3][31] ? (32'd0 - trow[3]) : trow[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vd[0] <= 1'b0;
    end else if (en) begin
      vd[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0].den <= den0;
      side[0].w   <= trow[3];
      side[0].zw  <= (trow[3] == 32'd0);
      side[0].sat <= |tsat;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_setup
    logic [31:0]      tabs;
    logic [NUM_W-1:0] num;
    assign tabs = trow[k][31] ? (32'd0 - trow[k]) : trow[k];
    assign num  = {tabs, {FRAC_BITS{1'b0}}};
    always_ff @(posedge clk) begin
      if (en) begin
        lane[0][k].rem  <= 32'(num[NUM_W-1:32]);
        lane[0][k].nlo  <= num[31:0];
        lane[0][k].quo  <= '0;
        lane[0][k].neg  <= trow[k][31] ^ trow[3][31];
        lane[0][k].ovf  <= 32'(num[NUM_W-1:32]) >= den0;
        lane[0][k].tneg <= trow[k][31];
        lane[0][k].tnz  <= (trow[k] != 32'd0);
      end
    end
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        vd[j+1] <= 1'b0;
      end else if (en) begin
        vd[j+1] <= vd[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[j+1] <= side[j];
      end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [32:0] trial;
      logic [32:0] diff;
      logic        ge;
      assign trial = {lane[j][k].rem, lane[j][k].nlo[31]};
      assign diff  = trial - {1'b0, side[j].den};
      assign ge    = !diff[32];
      always_ff @(posedge clk) begin
        if (en) begin
          lane[j+1][k].rem  <= ge ? diff[31:0] : trial[31:0];
          lane[j+1][k].nlo  <= {lane[j][k].nlo[30:0], 1'b0};
          lane[j+1][k].quo  <= {lane[j][k].quo[30:0], ge};
          lane[j+1][k].neg  <= lane[j][k].neg;
          lane[j+1][k].ovf  <= lane[j][k].ovf;
          lane[j+1][k].tneg <= lane[j][k].tneg;
          lane[j+1][k].tnz  <= lane[j][k].tnz;
        end
      end
    end
  end

  // Output register: sign, quotient clipping and the zero-w special case.
  logic [31:0] qres [3];
  logic [2:0]  qsat;

  for (genvar k = 0; k < 3; k++) begin : g_fin
    vtp_lane_t l;
    assign l = lane[DIV_STAGES][k];
    always_comb begin
      qsat[k] = 1'b0;
      if (side[DIV_STAGES].zw) begin
        qres[k] = l.tnz ? (l.tneg ? S32_MIN : S32_MAX) : 32'd0;
      end else if (l.ovf) begin
        qres[k] = l.neg ? S32_MIN : S32_MAX;
        qsat[k] = 1'b1;
      end else if (!l.neg) begin
        qres[k] = l.quo[31] ? S32_MAX : l.quo;
        qsat[k] = l.quo[31];
      end else if (l.quo > S32_MIN) begin
        qres[k] = S32_MIN;
        qsat[k] = 1'b1;
      end else begin
        qres[k] = 32'd0 - l.quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= vd[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x      <= qres[0];
      out_y      <= qres[1];
      out_z      <= qres[2];
      out_w      <= side[DIV_STAGES].w;
      w_was_zero <= side[DIV_STAGES].zw;
      saturated  <= side[DIV_STAGES].sat || (|qsat);
    end
  end

  // A zero w flag must come with a zero w value.
  a_zero_w : assert property (@(posedge clk) disable iff (rst)
    result_valid && w_was_zero |-> out_w == 32'd0)
    else $error("w_was_zero set with nonzero out_w");

  // The first stage and the output are not valid right after reset.
  a_reset_clears : assert property (@(posedge clk)
    $past(rst) |-> !result_valid && !v1)
    else $error("valid bit survived reset");

  // The first stage only fills from an accepted vertex transaction.
  a_fill_from_accept : assert property (@(posedge clk) disable iff (rst)
    $rose(v1) |-> $past(vertex_valid && vertex_ready))
    else $error("stage 1 filled without a transaction");

endmodule
